[rtl/anl_pkg.sv]
package anl_pkg;

	localparam int SLOTS = 8;
	localparam int SLOT_IW = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam int PAD_W = 7;
	localparam int NOTE_W = 7;
	localparam int VEL_W = 7;
	localparam int CHAN_W = 4;
	localparam int OVEL_W = 6;
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 7;

	localparam logic [CFG_IW-1:0] REG_CLEAR_PAD = 1'd0;
	localparam logic [CFG_IW-1:0] REG_CHANNEL = 1'd1;

	localparam logic [PAD_W-1:0] CLEAR_PAD_RST = 7'd81;
	localparam logic [CHAN_W-1:0] CHANNEL_RST = 4'd8;
	localparam logic [VEL_W:0] VEL_OFFSET = 8'd10;

	localparam logic [1:0] OP_NOP = 2'd0;
	localparam logic [1:0] OP_PRESS = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	typedef struct packed {
		logic [PAD_W-1:0] pad;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0] vel;
	} slot_t;

	typedef struct packed {
		logic active;
		logic [1:0] op;
		logic found;
		logic done;
		logic hit;
		logic inserted;
		logic [PAD_W-1:0] pad;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0] vel;
		logic [NOTE_W-1:0] res_note;
		logic [VEL_W-1:0] res_vel;
	} pkt_t;

endpackage

[rtl/anl_cell.sv]
module anl_cell (
	input logic clk,
	input logic arst_n,
	input logic [anl_pkg::SLOT_IW-1:0] idx,
	input logic [anl_pkg::SLOT_IW-1:0] ptr,
	input anl_pkg::pkt_t pkt_in,
	input anl_pkg::slot_t nxt,
	output anl_pkg::slot_t slot,
	output anl_pkg::pkt_t pkt_out
);

	anl_pkg::slot_t slot_q;
	anl_pkg::slot_t slot_n;
	anl_pkg::pkt_t pkt_q;
	anl_pkg::pkt_t pkt_n;

	always_comb begin
		pkt_n = pkt_in;
		slot_n = slot_q;
		if (pkt_in.active) begin
			case (pkt_in.op)
				anl_pkg::OP_CLEAR: begin
					slot_n = '0;
				end
				anl_pkg::OP_TICK: begin
					if (idx == ptr && slot_q.note != '0) begin
						pkt_n.hit = 1'b1;
						pkt_n.res_note = slot_q.note;
						pkt_n.res_vel = slot_q.vel;
					end
				end
				anl_pkg::OP_PRESS: begin
					if (pkt_in.found) begin
						slot_n = nxt;
					end else if (!pkt_in.done) begin
						if (slot_q.note != '0 && slot_q.pad == pkt_in.pad) begin
							pkt_n.found = 1'b1;
							pkt_n.done = 1'b1;
							pkt_n.hit = 1'b1;
							pkt_n.res_note = slot_q.note;
							pkt_n.res_vel = '0;
							slot_n = nxt;
						end else if (slot_q.note == '0) begin
							slot_n.pad = pkt_in.pad;
							slot_n.note = pkt_in.note;
							slot_n.vel = pkt_in.vel;
							pkt_n.inserted = 1'b1;
							pkt_n.done = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			pkt_q <= '0;
		end else begin
			slot_q <= slot_n;
			pkt_q <= pkt_n;
		end
	end

	assign slot = slot_q;
	assign pkt_out = pkt_q;

endmodule

[rtl/arpeggiator_note_list_unit.sv]
// Each item travels down the row of slot cells, one cell per cycle.
// The accepted item is registered into an injection register, then into each slot cell in turn.
// A new item is not accepted while one is in the row; busy stays high until the last cell is passed.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset empties every slot, zeroes the count and pointer and restores the registers.
module arpeggiator_note_list_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [0:0] func,
	input logic [anl_pkg::PAD_W-1:0] pad,
	input logic [anl_pkg::NOTE_W-1:0] key_note,
	input logic [anl_pkg::VEL_W-1:0] strike,
	input logic cfg_we,
	input logic [anl_pkg::CFG_IW-1:0] cfg_idx,
	input logic [anl_pkg::CFG_DW-1:0] cfg_wdata,
	output logic strobe,
	output logic [0:0] is_note_on,
	output logic [anl_pkg::CHAN_W-1:0] out_channel,
	output logic [anl_pkg::NOTE_W-1:0] out_note,
	output logic [anl_pkg::OVEL_W-1:0] out_velocity
);

	logic [anl_pkg::PAD_W-1:0] clear_pad_q;
	logic [anl_pkg::CHAN_W-1:0] channel_q;
	logic busy_q;
	logic [anl_pkg::CNT_W-1:0] count_q;
	logic [anl_pkg::SLOT_IW-1:0] step_q;
	logic [anl_pkg::CNT_W-1:0] step_inc;
	anl_pkg::pkt_t inj_q;
	anl_pkg::pkt_t inj_n;
	anl_pkg::pkt_t last;
	anl_pkg::slot_t slots [anl_pkg::SLOTS];
	anl_pkg::pkt_t pkts [anl_pkg::SLOTS];
	logic accept;
	logic [anl_pkg::VEL_W:0] vel_sum;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_pad_q <= anl_pkg::CLEAR_PAD_RST;
			channel_q <= anl_pkg::CHANNEL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				anl_pkg::REG_CLEAR_PAD: clear_pad_q <= cfg_wdata[anl_pkg::PAD_W-1:0];
				anl_pkg::REG_CHANNEL: channel_q <= cfg_wdata[anl_pkg::CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		inj_n = '0;
		if (accept) begin
			inj_n.active = 1'b1;
			inj_n.pad = pad;
			inj_n.note = key_note;
			inj_n.vel = strike;
			if (func == 1'b1) begin
				inj_n.op = anl_pkg::OP_TICK;
			end else if (pad == clear_pad_q) begin
				inj_n.op = anl_pkg::OP_CLEAR;
			end else if (key_note == '0 || strike == '0) begin
				inj_n.op = anl_pkg::OP_NOP;
			end else begin
				inj_n.op = anl_pkg::OP_PRESS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_q <= '0;
		end else begin
			inj_q <= inj_n;
		end
	end

	for (genvar i = 0; i < anl_pkg::SLOTS; i++) begin : g_cell
		anl_pkg::pkt_t cell_in;
		anl_pkg::slot_t cell_nxt;
		if (i == 0) begin : g_first
			assign cell_in = inj_q;
		end else begin : g_mid
			assign cell_in = pkts[i-1];
		end
		if (i == anl_pkg::SLOTS - 1) begin : g_end
			assign cell_nxt = '0;
		end else begin : g_inner
			assign cell_nxt = slots[i+1];
		end
		anl_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.idx(anl_pkg::SLOT_IW'(i)),
			.ptr(step_q),
			.pkt_in(cell_in),
			.nxt(cell_nxt),
			.slot(slots[i]),
			.pkt_out(pkts[i])
		);
	end

	assign last = pkts[anl_pkg::SLOTS-1];
	assign step_inc = anl_pkg::CNT_W'(step_q) + anl_pkg::CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			count_q <= '0;
			step_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last.active) begin
				busy_q <= 1'b0;
			end
			if (last.active) begin
				case (last.op)
					anl_pkg::OP_CLEAR: begin
						count_q <= '0;
					end
					anl_pkg::OP_PRESS: begin
						if (last.found) begin
							count_q <= count_q - anl_pkg::CNT_W'(1);
						end else if (last.inserted) begin
							count_q <= count_q + anl_pkg::CNT_W'(1);
						end
					end
					anl_pkg::OP_TICK: begin
						if (count_q == '0 || step_inc >= count_q) begin
							step_q <= '0;
						end else begin
							step_q <= step_inc[anl_pkg::SLOT_IW-1:0];
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign vel_sum = anl_pkg::VEL_OFFSET + {1'b0, last.res_vel};

	assign busy = busy_q;
	assign strobe = last.active && last.hit;
	assign is_note_on = (last.op == anl_pkg::OP_TICK) ? 1'b1 : 1'b0;
	assign out_channel = channel_q;
	assign out_note = last.res_note;
	assign out_velocity = (last.op == anl_pkg::OP_TICK) ? vel_sum[anl_pkg::VEL_W:2] : '0;

endmodule

[rtl/anl_checker.sv]
module anl_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic [0:0] is_note_on,
	input logic [anl_pkg::NOTE_W-1:0] out_note,
	input logic [anl_pkg::OVEL_W-1:0] out_velocity
);

	a_strobe_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result strobe outside a busy period");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe && !busy) else $error("more than one result for one item");

	a_note_off_vel: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_note_on |-> out_velocity == '0)
		else $error("note-off carries a non-zero velocity");

	a_note_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> out_note != '0) else $error("result names an empty note");

endmodule

bind arpeggiator_note_list_unit anl_checker u_anl_checker (.*);

[tb/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic FUNC_PRESS = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 135;
	localparam int DRAIN_LIMIT = 1000;

	typedef struct packed {
		logic on;
		logic [anl_pkg::CHAN_W-1:0] chan;
		logic [anl_pkg::NOTE_W-1:0] note;
		logic [anl_pkg::OVEL_W-1:0] vel;
	} arp_msg_t;

	class arp_tracker;
		logic [anl_pkg::PAD_W-1:0] clear_pad;
		logic [anl_pkg::CHAN_W-1:0] channel;
		logic [anl_pkg::PAD_W-1:0] held_pad[anl_pkg::SLOTS];
		logic [anl_pkg::NOTE_W-1:0] held_note[anl_pkg::SLOTS];
		logic [anl_pkg::VEL_W-1:0] held_vel[anl_pkg::SLOTS];
		int held_count;
		int step_ptr;
		arp_msg_t expected_msgs[$];
		int errors;

		function new();
			clear_pad = anl_pkg::CLEAR_PAD_RST;
			channel = anl_pkg::CHANNEL_RST;
			empty_list();
			step_ptr = 0;
			errors = 0;
		endfunction

		function void empty_list();
			for (int i = 0; i < anl_pkg::SLOTS; i++) begin
				held_pad[i] = '0;
				held_note[i] = '0;
				held_vel[i] = '0;
			end
			held_count = 0;
		endfunction

		function void set_reg(logic [anl_pkg::CFG_IW-1:0] idx,
				logic [anl_pkg::CFG_DW-1:0] data);
			case (idx)
				anl_pkg::REG_CLEAR_PAD: clear_pad = data[anl_pkg::PAD_W-1:0];
				anl_pkg::REG_CHANNEL: channel = data[anl_pkg::CHAN_W-1:0];
				default: ;
			endcase
		endfunction

		function void push_msg(logic on, logic [anl_pkg::NOTE_W-1:0] note, int vel);
			arp_msg_t m;
			m.on = on;
			m.chan = channel;
			m.note = note;
			m.vel = vel[anl_pkg::OVEL_W-1:0];
			expected_msgs.push_back(m);
		endfunction

		function void take_item(logic f, logic [anl_pkg::PAD_W-1:0] p,
				logic [anl_pkg::NOTE_W-1:0] n, logic [anl_pkg::VEL_W-1:0] v);
			int hit;
			hit = -1;
			if (f == FUNC_TICK) begin
				if (held_note[step_ptr] != 0)
					push_msg(1'b1, held_note[step_ptr],
						(int'(anl_pkg::VEL_OFFSET) + int'(held_vel[step_ptr])) >> 2);
				if (held_count == 0 || step_ptr + 1 >= held_count)
					step_ptr = 0;
				else
					step_ptr++;
				return;
			end
			if (p == clear_pad) begin
				empty_list();
				return;
			end
			if (n == 0 || v == 0)
				return;
			for (int i = 0; i < anl_pkg::SLOTS; i++)
				if (hit < 0 && held_pad[i] == p && held_note[i] != 0)
					hit = i;
			if (hit >= 0) begin
				push_msg(1'b0, held_note[hit], 0);
				for (int j = hit; j < anl_pkg::SLOTS - 1; j++) begin
					held_pad[j] = held_pad[j + 1];
					held_note[j] = held_note[j + 1];
					held_vel[j] = held_vel[j + 1];
				end
				held_pad[anl_pkg::SLOTS - 1] = '0;
				held_note[anl_pkg::SLOTS - 1] = '0;
				held_vel[anl_pkg::SLOTS - 1] = '0;
				if (held_count > 0)
					held_count--;
				return;
			end
			for (int i = 0; i < anl_pkg::SLOTS; i++)
				if (held_note[i] == 0) begin
					held_pad[i] = p;
					held_note[i] = n;
					held_vel[i] = v;
					if (held_count < anl_pkg::SLOTS)
						held_count++;
					return;
				end
		endfunction

		function void check_message(logic on, logic [anl_pkg::CHAN_W-1:0] chan,
				logic [anl_pkg::NOTE_W-1:0] note, logic [anl_pkg::OVEL_W-1:0] vel);
			arp_msg_t want;
			if (expected_msgs.size() == 0) begin
				$error("unexpected message: is_note_on=%0d out_channel=%0d %s%0d %s%0d",
					on, chan, "out_note=", note, "out_velocity=", vel);
				errors++;
				return;
			end
			want = expected_msgs.pop_front();
			if (on !== want.on) begin
				$error("is_note_on: expected %0d, actual %0d", want.on, on);
				errors++;
			end
			if (chan !== want.chan) begin
				$error("out_channel: expected %0d, actual %0d", want.chan, chan);
				errors++;
			end
			if (note !== want.note) begin
				$error("out_note: expected %0d, actual %0d", want.note, note);
				errors++;
			end
			if (vel !== want.vel) begin
				$error("out_velocity: expected %0d, actual %0d", want.vel, vel);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [0:0] func;
	logic [anl_pkg::PAD_W-1:0] pad;
	logic [anl_pkg::NOTE_W-1:0] key_note;
	logic [anl_pkg::VEL_W-1:0] strike;
	logic cfg_we;
	logic [anl_pkg::CFG_IW-1:0] cfg_idx;
	logic [anl_pkg::CFG_DW-1:0] cfg_wdata;
	logic strobe;
	logic [0:0] is_note_on;
	logic [anl_pkg::CHAN_W-1:0] out_channel;
	logic [anl_pkg::NOTE_W-1:0] out_note;
	logic [anl_pkg::OVEL_W-1:0] out_velocity;

	arp_tracker sb;

	arpeggiator_note_list_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.pad(pad),
		.key_note(key_note),
		.strike(strike),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.strobe(strobe),
		.is_note_on(is_note_on),
		.out_channel(out_channel),
		.out_note(out_note),
		.out_velocity(out_velocity)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_message(is_note_on, out_channel, out_note, out_velocity);
	end

	task automatic send(input logic f, input logic [anl_pkg::PAD_W-1:0] p,
			input logic [anl_pkg::NOTE_W-1:0] n, input logic [anl_pkg::VEL_W-1:0] v,
			input bit may_idle);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		pad <= p;
		key_note <= n;
		strike <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.take_item(f, p, n, v);
	endtask

	task automatic program_regs(input logic [anl_pkg::PAD_W-1:0] clr,
			input logic [anl_pkg::CHAN_W-1:0] chan);
		logic [anl_pkg::CFG_DW-1:0] chan_word;
		chan_word = anl_pkg::CFG_DW'($urandom_range(0, 127));
		chan_word[anl_pkg::CHAN_W-1:0] = chan;
		cfg_we <= 1'b1;
		cfg_idx <= anl_pkg::REG_CLEAR_PAD;
		cfg_wdata <= clr;
		@(posedge clk);
		sb.set_reg(anl_pkg::REG_CLEAR_PAD, clr);
		cfg_idx <= anl_pkg::REG_CHANNEL;
		cfg_wdata <= chan_word;
		@(posedge clk);
		sb.set_reg(anl_pkg::REG_CHANNEL, chan_word);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (sb.expected_msgs.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (anl_pkg::SLOTS + 4) @(posedge clk);
		if (sb.expected_msgs.size() != 0) begin
			$error("%0d expected messages never arrived", sb.expected_msgs.size());
			sb.errors++;
			sb.expected_msgs.delete();
		end
	endtask

	initial begin
		int sel;
		logic f;
		logic [anl_pkg::PAD_W-1:0] p;
		logic [anl_pkg::NOTE_W-1:0] n;
		logic [anl_pkg::VEL_W-1:0] v;

		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FUNC_PRESS;
		pad <= '0;
		key_note <= '0;
		strike <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= anl_pkg::REG_CLEAR_PAD;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(FUNC_TICK, 7'd0, 7'd0, 7'd0, 1'b1);
		send(FUNC_PRESS, 7'd0, 7'd127, 7'd127, 1'b1);
		send(FUNC_PRESS, 7'd127, 7'd1, 7'd1, 1'b1);
		send(FUNC_PRESS, 7'd5, 7'd0, 7'd50, 1'b1);
		send(FUNC_PRESS, 7'd5, 7'd60, 7'd0, 1'b1);
		send(FUNC_TICK, 7'd127, 7'd127, 7'd127, 1'b1);
		send(FUNC_TICK, 7'd0, 7'd0, 7'd0, 1'b1);
		send(FUNC_PRESS, 7'd0, 7'd99, 7'd9, 1'b1);
		for (int k = 0; k < anl_pkg::SLOTS; k++)
			send(FUNC_PRESS, anl_pkg::PAD_W'(10 + k), anl_pkg::NOTE_W'(20 + k),
				anl_pkg::VEL_W'(64 + k), 1'b0);
		repeat (3) send(FUNC_TICK, 7'd0, 7'd0, 7'd0, 1'b0);
		send(FUNC_PRESS, 7'd10, 7'd33, 7'd44, 1'b0);
		send(FUNC_PRESS, anl_pkg::CLEAR_PAD_RST, 7'd0, 7'd0, 1'b1);
		repeat (2) send(FUNC_TICK, 7'd0, 7'd0, 7'd0, 1'b1);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: program_regs(7'd0, 4'd0);
				1: program_regs(7'd127, 4'd15);
				default: program_regs(anl_pkg::PAD_W'($urandom_range(0, 127)),
					anl_pkg::CHAN_W'($urandom_range(0, 15)));
			endcase
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				sel = $urandom_range(0, 99);
				f = FUNC_PRESS;
				p = anl_pkg::PAD_W'($urandom_range(0, 11) * 11);
				n = anl_pkg::NOTE_W'($urandom_range(1, 127));
				v = anl_pkg::VEL_W'($urandom_range(1, 127));
				if (sel < 35) begin
					f = FUNC_TICK;
					p = anl_pkg::PAD_W'($urandom_range(0, 127));
					n = anl_pkg::NOTE_W'($urandom_range(0, 127));
					v = anl_pkg::VEL_W'($urandom_range(0, 127));
				end else if (sel < 38) begin
					p = sb.clear_pad;
					n = anl_pkg::NOTE_W'($urandom_range(0, 127));
					v = anl_pkg::VEL_W'($urandom_range(0, 127));
				end else if (sel < 44)
					n = '0;
				else if (sel < 50)
					v = '0;
				else if (sel < 58)
					p = anl_pkg::PAD_W'($urandom_range(0, 127));
				send(f, p, n, v, phase != PHASES - 1);
			end
			drain();
		end

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
